### rtl/cvs_pkg.sv
// ---------------------------------------------------------------------------
// cvs_pkg: shared types and constants for the strided 2D correlation block
// Geometry limits, register indexes, operation codes and the job record
// passed from the front end to the MAC engine.
// ---------------------------------------------------------------------------
package cvs_pkg;

   localparam int MaxCols   = 64;
   localparam int MaxKernel = 8;
   localparam int Taps      = MaxKernel * MaxKernel;
   localparam int Lines     = MaxKernel * MaxCols;

   localparam int ColW  = $clog2(MaxCols);
   localparam int KrW   = $clog2(MaxKernel);
   localparam int TapW  = $clog2(Taps);
   localparam int LineW = $clog2(Lines);
   localparam int SumW  = 38;
   localparam int DataW = 16;
   localparam int CsrW  = 11;
   localparam int CsrIdxW = 3;

   // register indexes
   localparam logic [CsrIdxW-1:0] RegInputRows  = 3'd0;
   localparam logic [CsrIdxW-1:0] RegInputCols  = 3'd1;
   localparam logic [CsrIdxW-1:0] RegKernelRows = 3'd2;
   localparam logic [CsrIdxW-1:0] RegKernelCols = 3'd3;
   localparam logic [CsrIdxW-1:0] RegStepSize   = 3'd4;

   // operation codes
   localparam logic OpLoadWeight = 1'b0;
   localparam logic OpSample     = 1'b1;

   // one window job
   typedef struct packed {
      logic [KrW-1:0]  r0_slot;   // line slot of window top row
      logic [ColW-1:0] c0;        // window left column
      logic [KrW:0]    kr;        // kernel rows in use, 1..MaxKernel
      logic [KrW:0]    kc;        // kernel cols in use
      logic            last;      // final window of the frame
   } job_type;

   typedef enum logic [1:0] {
      MAC_IDLE,
      MAC_READ,
      MAC_DONE
   } mac_state_type;

endpackage

### rtl/conv2d_valid_strided.sv
// ---------------------------------------------------------------------------
// conv2d_valid_strided: single-channel 2D valid cross-correlation, strided
// Front end tracks position and posts window jobs into a 2-entry queue; the
// MAC engine sums kernel-times-window products one tap per cycle.
// ---------------------------------------------------------------------------
//  channel  ports                             beat taken when
//  req      push, full, req_*                 push && !full
//  rsp      empty, pop, rsp_*                 pop && !empty
//  csr      csr_wr_en, csr_index, csr_data    csr_wr_en
//
// The MAC engine reads a window job one tap per cycle through the weight and
// line store read ports. full is high while a job waits in the queue or the
// engine reads the stores, so no beat overwrites a window still being summed:
// after a window-closing sample the input waits until the engine has read the
// whole window, longer while a result is not popped. Reset is synchronous;
// stores are not cleared.
// ---------------------------------------------------------------------------
module conv2d_valid_strided (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  logic                        req_operation,
   input  logic [5:0]                  req_weight_index,
   input  logic signed [15:0]          req_data_value,
   output logic                        empty,
   input  logic                        pop,
   output logic signed [37:0]          rsp_conv_sum,
   output logic                        rsp_last_in_frame,
   input  logic                        csr_wr_en,
   input  logic [cvs_pkg::CsrIdxW-1:0] csr_index,
   input  logic [cvs_pkg::CsrW-1:0]    csr_data
);

   logic item_stall, wgt_wr_en, line_wr_en, job_push, job_pop, res_valid, res_last;
   logic mac_rd_busy;
   logic [cvs_pkg::LineW-1:0] line_wr_addr, line_rd_addr;
   logic [cvs_pkg::TapW-1:0] wgt_rd_addr;
   logic [cvs_pkg::DataW-1:0] wgt_rd_data, line_rd_data;
   logic [cvs_pkg::SumW-1:0] res_sum;
   cvs_pkg::job_type job_new, job_head;
   cvs_pkg::job_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic rd_ff, rd_in, wr_ff, wr_in;

   // classifier
   cvs_front u_front (
      .clock, .reset,
      .csr_wr_en, .csr_index, .csr_data,
      .item_valid(push && !full),
      .item_op(req_operation),
      .item_stall,
      .wgt_wr_en, .line_wr_en, .line_wr_addr,
      .job_push, .job(job_new),
      .job_full(cnt_ff == 2'd2)
   );

   // hold the input while a window is pending or being read
   assign full = (cnt_ff != 2'd0) || mac_rd_busy;

   cvs_ram #(.Width(cvs_pkg::DataW), .Depth(cvs_pkg::Taps)) u_wgt_ram (
      .clock, .wr_en(wgt_wr_en), .wr_addr(req_weight_index),
      .wr_data(req_data_value), .rd_addr(wgt_rd_addr), .rd_data(wgt_rd_data)
   );

   cvs_ram #(.Width(cvs_pkg::DataW), .Depth(cvs_pkg::Lines)) u_line_ram (
      .clock, .wr_en(line_wr_en), .wr_addr(line_wr_addr),
      .wr_data(req_data_value), .rd_addr(line_rd_addr), .rd_data(line_rd_data)
   );

   // two-entry job queue
   always_comb begin
      cnt_in = cnt_ff + 2'(job_push) - 2'(job_pop);
      rd_in = rd_ff ^ job_pop;
      wr_in = wr_ff ^ job_push;
      job_head = q_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
         wr_ff <= wr_in;
      end
      if (job_push) q_ff[wr_ff] <= job_new;
   end

   cvs_mac u_mac (
      .clock, .reset,
      .job_valid(cnt_ff != 2'd0 && !item_stall),
      .job(job_head), .job_pop,
      .rd_busy(mac_rd_busy),
      .wgt_rd_addr, .wgt_rd_data, .line_rd_addr, .line_rd_data,
      .res_valid, .res_sum, .res_last,
      .res_taken(pop)
   );

   assign empty = !res_valid;
   assign rsp_conv_sum = $signed(res_sum);
   assign rsp_last_in_frame = res_last;

endmodule

### rtl/cvs_ram.sv
// ---------------------------------------------------------------------------
// cvs_ram: generic single-port-write, single-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module cvs_ram #(
   parameter int Width = 16,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/cvs_front.sv
// ---------------------------------------------------------------------------
// cvs_front: item classifier and position tracker
// Holds geometry registers, walks the raster position, writes samples into
// the line store, and posts a window job when a sample closes a window on
// the stride grid.
// ---------------------------------------------------------------------------
module cvs_front (
   input  logic                         clock,
   input  logic                         reset,
   // configuration
   input  logic                         csr_wr_en,
   input  logic [cvs_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [cvs_pkg::CsrW-1:0]     csr_data,
   // item beat (already qualified)
   input  logic                         item_valid,
   input  logic                         item_op,
   output logic                         item_stall,
   // storage writes
   output logic                         wgt_wr_en,
   output logic                         line_wr_en,
   output logic [cvs_pkg::LineW-1:0]    line_wr_addr,
   // job queue push
   output logic                         job_push,
   output cvs_pkg::job_type             job,
   input  logic                         job_full
);

   logic [10:0] rows_cfg_ff, rows_cfg_in;
   logic [6:0]  cols_cfg_ff, cols_cfg_in;
   logic [3:0]  kr_cfg_ff, kr_cfg_in, kc_cfg_ff, kc_cfg_in, st_cfg_ff, st_cfg_in;
   logic [9:0]  row_ff, row_in;
   logic [cvs_pkg::ColW-1:0] col_ff, col_in;
   // stride phase counters: distance from last grid point
   logic [2:0]  rph_ff, rph_in, cph_ff, cph_in;

   logic [10:0] rows;
   logic [6:0]  cols;
   logic [cvs_pkg::KrW:0] kr, kc;
   logic [3:0]  st;
   logic [10:0] r1;
   logic [6:0]  c1;
   logic        row_ok, col_ok, is_sample, fire;
   logic [10:0] r0;
   logic [6:0]  c0;
   logic [10:0] row_span, last_r0;
   logic [6:0]  col_span, last_c0;
   logic        row_end, frame_end;

   // saturate geometry
   always_comb begin
      rows = (rows_cfg_ff == 11'd0) ? 11'd1 :
             (rows_cfg_ff > 11'd1024) ? 11'd1024 : rows_cfg_ff;
      cols = (cols_cfg_ff == 7'd0) ? 7'd1 :
             (cols_cfg_ff > 7'(cvs_pkg::MaxCols)) ? 7'(cvs_pkg::MaxCols) : cols_cfg_ff;
      kr = (kr_cfg_ff == 4'd0) ? 4'd1 :
           (kr_cfg_ff > 4'(cvs_pkg::MaxKernel)) ? 4'(cvs_pkg::MaxKernel) : kr_cfg_ff;
      kc = (kc_cfg_ff == 4'd0) ? 4'd1 :
           (kc_cfg_ff > 4'(cvs_pkg::MaxKernel)) ? 4'(cvs_pkg::MaxKernel) : kc_cfg_ff;
      st = (st_cfg_ff == 4'd0) ? 4'd1 : (st_cfg_ff > 4'd8) ? 4'd8 : st_cfg_ff;
   end

   // window test
   always_comb begin
      r1 = 11'(row_ff) + 11'd1;
      c1 = 7'(col_ff) + 7'd1;
      row_ok = (11'(kr) <= rows) && (r1 >= 11'(kr));
      col_ok = (7'(kc) <= cols) && (c1 >= 7'(kc));
      r0 = r1 - 11'(kr);
      c0 = c1 - 7'(kc);
      row_span = rows - 11'(kr);
      col_span = cols - 7'(kc);
      is_sample = item_valid && (item_op == cvs_pkg::OpSample);
      fire = is_sample && row_ok && col_ok && (rph_ff == 3'd0) && (cph_ff == 3'd0);
      row_end = (c1 == cols);
      frame_end = row_end && (r1 == rows);
   end

   // last window: no grid point lies between this one and the frame edge
   always_comb begin
      last_r0 = row_span - r0;
      last_c0 = col_span - c0;
   end

   assign item_stall = is_sample && job_full;

   // storage and job
   always_comb begin
      wgt_wr_en = item_valid && (item_op == cvs_pkg::OpLoadWeight);
      line_wr_en = is_sample && !job_full;
      line_wr_addr = {row_ff[cvs_pkg::KrW-1:0], col_ff};
      job_push = fire && !job_full;
      job.r0_slot = r0[cvs_pkg::KrW-1:0];
      job.c0 = c0[cvs_pkg::ColW-1:0];
      job.kr = kr;
      job.kc = kc;
      job.last = (last_r0 < 11'(st)) && (last_c0 < 7'(st));
   end

   // position, phase and registers
   always_comb begin
      rows_cfg_in = rows_cfg_ff;
      cols_cfg_in = cols_cfg_ff;
      kr_cfg_in = kr_cfg_ff;
      kc_cfg_in = kc_cfg_ff;
      st_cfg_in = st_cfg_ff;
      row_in = row_ff;
      col_in = col_ff;
      rph_in = rph_ff;
      cph_in = cph_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            cvs_pkg::RegInputRows:  rows_cfg_in = csr_data;
            cvs_pkg::RegInputCols:  cols_cfg_in = csr_data[6:0];
            cvs_pkg::RegKernelRows: kr_cfg_in = csr_data[3:0];
            cvs_pkg::RegKernelCols: kc_cfg_in = csr_data[3:0];
            cvs_pkg::RegStepSize:   st_cfg_in = csr_data[3:0];
            default: ;
         endcase
         if (csr_index <= cvs_pkg::RegStepSize) begin
            row_in = '0;
            col_in = '0;
            rph_in = '0;
            cph_in = '0;
         end
      end else if (is_sample && !job_full) begin
         // column phase counts once the window's left edge is in range
         if (col_ok) begin
            cph_in = (cph_ff == 3'(st - 4'd1)) ? 3'd0 : cph_ff + 3'd1;
         end
         col_in = col_ff + cvs_pkg::ColW'(1);
         if (row_end) begin
            col_in = '0;
            cph_in = '0;
            row_in = row_ff + 10'd1;
            if (row_ok) begin
               rph_in = (rph_ff == 3'(st - 4'd1)) ? 3'd0 : rph_ff + 3'd1;
            end
            if (frame_end) begin
               row_in = '0;
               rph_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff <= 11'd64;
         cols_cfg_ff <= 7'd64;
         kr_cfg_ff <= 4'd3;
         kc_cfg_ff <= 4'd3;
         st_cfg_ff <= 4'd1;
         row_ff <= '0;
         col_ff <= '0;
         rph_ff <= '0;
         cph_ff <= '0;
      end else begin
         rows_cfg_ff <= rows_cfg_in;
         cols_cfg_ff <= cols_cfg_in;
         kr_cfg_ff <= kr_cfg_in;
         kc_cfg_ff <= kc_cfg_in;
         st_cfg_ff <= st_cfg_in;
         row_ff <= row_in;
         col_ff <= col_in;
         rph_ff <= rph_in;
         cph_ff <= cph_in;
      end
   end

endmodule

### rtl/cvs_mac.sv
// ---------------------------------------------------------------------------
// cvs_mac: window MAC engine
// Takes one job, reads one weight and one sample per cycle from the stores,
// and accumulates the products into a 38-bit sum.
// ---------------------------------------------------------------------------
module cvs_mac (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   input  cvs_pkg::job_type              job,
   output logic                          job_pop,
   output logic                          rd_busy,
   output logic [cvs_pkg::TapW-1:0]      wgt_rd_addr,
   input  logic [cvs_pkg::DataW-1:0]     wgt_rd_data,
   output logic [cvs_pkg::LineW-1:0]     line_rd_addr,
   input  logic [cvs_pkg::DataW-1:0]     line_rd_data,
   output logic                          res_valid,
   output logic [cvs_pkg::SumW-1:0]      res_sum,
   output logic                          res_last,
   input  logic                          res_taken
);

   cvs_pkg::mac_state_type state_ff, state_in;
   cvs_pkg::job_type job_ff, job_in;
   logic [cvs_pkg::KrW:0] i_ff, i_in, j_ff, j_in;
   logic [cvs_pkg::TapW-1:0] tap_ff, tap_in;
   logic rd_vld_ff, rd_vld_in, rd_end_ff, rd_end_in;
   logic prod_vld_ff, prod_end_ff;
   logic signed [31:0] prod_ff;
   logic [cvs_pkg::SumW-1:0] acc_ff, acc_in;
   logic [cvs_pkg::SumW-1:0] sum_ff;
   logic last_ff, res_vld_ff, res_vld_in;
   logic issue_end;
   logic [cvs_pkg::ColW:0] col_sum;
   logic [cvs_pkg::KrW:0] slot_sum;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cvs_pkg::MAC_IDLE: if (job_valid && !res_vld_ff) state_in = cvs_pkg::MAC_READ;
         cvs_pkg::MAC_READ: if (issue_end) state_in = cvs_pkg::MAC_DONE;
         cvs_pkg::MAC_DONE: if (prod_vld_ff && prod_end_ff) state_in = cvs_pkg::MAC_IDLE;
         default: state_in = cvs_pkg::MAC_IDLE;
      endcase
   end

   // read address walk
   always_comb begin
      issue_end = (i_ff == job_ff.kr - (cvs_pkg::KrW+1)'(1)) &&
                  (j_ff == job_ff.kc - (cvs_pkg::KrW+1)'(1));
      slot_sum = {1'b0, job_ff.r0_slot} + i_ff;
      col_sum = {1'b0, job_ff.c0} + (cvs_pkg::ColW+1)'(j_ff);
      wgt_rd_addr = tap_ff;
      line_rd_addr = {slot_sum[cvs_pkg::KrW-1:0], col_sum[cvs_pkg::ColW-1:0]};
   end

   // stores are being read; writes must wait
   assign rd_busy = (state_ff == cvs_pkg::MAC_READ);

   // outputs and counters
   always_comb begin
      job_pop = (state_ff == cvs_pkg::MAC_IDLE) && job_valid && !res_vld_ff;
      job_in = job_ff;
      i_in = i_ff;
      j_in = j_ff;
      tap_in = tap_ff;
      rd_vld_in = 1'b0;
      rd_end_in = 1'b0;
      acc_in = acc_ff;
      res_vld_in = res_vld_ff && !res_taken;
      if (job_pop) begin
         job_in = job;
         i_in = '0;
         j_in = '0;
         tap_in = '0;
         acc_in = '0;
      end
      if (state_ff == cvs_pkg::MAC_READ) begin
         rd_vld_in = 1'b1;
         rd_end_in = issue_end;
         tap_in = tap_ff + cvs_pkg::TapW'(1);
         if (j_ff == job_ff.kc - (cvs_pkg::KrW+1)'(1)) begin
            j_in = '0;
            i_in = i_ff + (cvs_pkg::KrW+1)'(1);
         end else begin
            j_in = j_ff + (cvs_pkg::KrW+1)'(1);
         end
      end
      if (prod_vld_ff) begin
         acc_in = acc_ff + cvs_pkg::SumW'(prod_ff);
         if (prod_end_ff) res_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cvs_pkg::MAC_IDLE;
         rd_vld_ff <= 1'b0;
         prod_vld_ff <= 1'b0;
         res_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rd_vld_ff <= rd_vld_in;
         prod_vld_ff <= rd_vld_ff;
         res_vld_ff <= res_vld_in;
      end
      job_ff <= job_in;
      i_ff <= i_in;
      j_ff <= j_in;
      tap_ff <= tap_in;
      rd_end_ff <= rd_end_in;
      prod_end_ff <= rd_end_ff;
      prod_ff <= 32'($signed(wgt_rd_data)) * 32'($signed(line_rd_data));
      acc_ff <= acc_in;
      if (prod_vld_ff && prod_end_ff) begin
         sum_ff <= acc_ff + cvs_pkg::SumW'(prod_ff);
         last_ff <= job_ff.last;
      end
   end

   assign res_valid = res_vld_ff;
   assign res_sum = sum_ff;
   assign res_last = last_ff;

endmodule

### sim/tb_conv2d_valid_strided.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_conv2d_valid_strided: self-checking bench for the strided 2D correlation
// Loads the full kernel, then streams sample frames through several
// geometries. Each accepted beat is run through an in-bench window model;
// results are compared in order with randomized push bursts and pop stalls.
// ---------------------------------------------------------------------------
module tb_conv2d_valid_strided;

   // index with no register behind it
   localparam logic [cvs_pkg::CsrIdxW-1:0] RegUnused = 3'd7;

   typedef struct {
      logic                             op;
      logic [5:0]                       idx;
      logic signed [cvs_pkg::DataW-1:0] data;
   } req_beat_type;

   typedef struct {
      logic signed [cvs_pkg::SumW-1:0] sum;
      logic                            last;
   } window_result_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            push = 1'b0;
   logic                            full;
   logic                            req_operation = cvs_pkg::OpSample;
   logic [5:0]                      req_weight_index = '0;
   logic signed [15:0]              req_data_value = '0;
   logic                            empty;
   logic                            pop = 1'b0;
   logic signed [37:0]              rsp_conv_sum;
   logic                            rsp_last_in_frame;
   logic                            csr_wr_en = 1'b0;
   logic [cvs_pkg::CsrIdxW-1:0]     csr_index = '0;
   logic [cvs_pkg::CsrW-1:0]        csr_data = '0;

   req_beat_type      pending_beats[$];
   window_result_type expected_windows[$];
   int                errors = 0;

   // window model state
   logic [10:0]                      frame_rows;
   logic [6:0]                       frame_cols;
   logic [3:0]                       kern_rows, kern_cols, stride;
   logic signed [cvs_pkg::DataW-1:0] kernel_taps[cvs_pkg::Taps];
   logic signed [cvs_pkg::DataW-1:0] row_buffer[cvs_pkg::Lines];
   int                               cur_row, cur_col;

   conv2d_valid_strided dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int clamp(int v, int lo, int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   // register write as the block sees it: any known index restarts the frame
   function automatic void model_csr(logic [cvs_pkg::CsrIdxW-1:0] idx,
                                     logic [cvs_pkg::CsrW-1:0] val);
      case (idx)
         cvs_pkg::RegInputRows:  frame_rows = val[10:0];
         cvs_pkg::RegInputCols:  frame_cols = val[6:0];
         cvs_pkg::RegKernelRows: kern_rows  = val[3:0];
         cvs_pkg::RegKernelCols: kern_cols  = val[3:0];
         cvs_pkg::RegStepSize:   stride     = val[3:0];
         default: return;
      endcase
      cur_row = 0;
      cur_col = 0;
   endfunction

   // one accepted beat; queues a window sum when the beat closes a strided window
   function automatic void model_beat(req_beat_type b);
      int rows, cols, kr, kc, s, r0, c0;
      longint acc;
      window_result_type res;
      rows = clamp(frame_rows, 1, 1024);
      cols = clamp(frame_cols, 1, cvs_pkg::MaxCols);
      kr   = clamp(kern_rows, 1, cvs_pkg::MaxKernel);
      kc   = clamp(kern_cols, 1, cvs_pkg::MaxKernel);
      s    = clamp(stride, 1, 8);
      if (b.op == cvs_pkg::OpLoadWeight) begin
         kernel_taps[b.idx] = b.data;
         return;
      end
      if (cur_row >= rows || cur_col >= cols) begin
         cur_row = 0;
         cur_col = 0;
      end
      row_buffer[(cur_row % cvs_pkg::MaxKernel) * cvs_pkg::MaxCols + cur_col] = b.data;
      if (kr <= rows && kc <= cols && cur_row + 1 >= kr && cur_col + 1 >= kc) begin
         r0 = cur_row + 1 - kr;
         c0 = cur_col + 1 - kc;
         if (r0 % s == 0 && c0 % s == 0) begin
            acc = 0;
            for (int i = 0; i < kr; i++)
               for (int j = 0; j < kc; j++)
                  acc += longint'(kernel_taps[i * kc + j]) *
                         longint'(row_buffer[((r0 + i) % cvs_pkg::MaxKernel) *
                                             cvs_pkg::MaxCols + c0 + j]);
            res.sum  = acc[cvs_pkg::SumW-1:0];
            res.last = (r0 == ((rows - kr) / s) * s) && (c0 == ((cols - kc) / s) * s);
            expected_windows.push_back(res);
         end
      end
      cur_col++;
      if (cur_col >= cols) begin
         cur_col = 0;
         cur_row++;
         if (cur_row >= rows) cur_row = 0;
      end
   endfunction

   // sender: bursts of random length with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      req_beat_type b;
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) model_beat('{req_operation, req_weight_index, req_data_value});
         if (push && full) begin
            // hold the beat
         end else if (gap_left > 0) begin
            gap_left--;
            push <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            b = pending_beats.pop_front();
            req_operation    <= b.op;
            req_weight_index <= b.idx;
            req_data_value   <= b.data;
            push             <= 1'b1;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            push <= 1'b0;
         end
      end
   end

   // receiver: stall pattern from a rotating random mask, reloaded after each full rotation
   logic [15:0] pop_mask = 16'hffff;
   int          mask_pos = 0;
   always @(posedge clock) begin
      window_result_type exp_res;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_windows.size() == 0) begin
               $error("unexpected result beat: conv_sum=%0d last=%0b",
                      rsp_conv_sum, rsp_last_in_frame);
               errors++;
            end else begin
               exp_res = expected_windows.pop_front();
               if (rsp_conv_sum !== exp_res.sum) begin
                  $error("conv_sum: expected %0d actual %0d", exp_res.sum, rsp_conv_sum);
                  errors++;
               end
               if (rsp_last_in_frame !== exp_res.last) begin
                  $error("last_in_frame: expected %0b actual %0b",
                         exp_res.last, rsp_last_in_frame);
                  errors++;
               end
            end
         end
         pop <= pop_mask[mask_pos];
         mask_pos = (mask_pos + 1) % 16;
         if (mask_pos == 0)
            pop_mask = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
      end
   end

   task automatic wait_idle();
      while (pending_beats.size() > 0 || push || expected_windows.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_csr(logic [cvs_pkg::CsrIdxW-1:0] idx,
                            logic [cvs_pkg::CsrW-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      model_csr(idx, val);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_geometry(int rows, int cols, int kr, int kc, int s);
      wait_idle();
      write_csr(cvs_pkg::RegInputRows, cvs_pkg::CsrW'(rows));
      write_csr(cvs_pkg::RegInputCols, cvs_pkg::CsrW'(cols));
      write_csr(cvs_pkg::RegKernelRows, cvs_pkg::CsrW'(kr));
      write_csr(cvs_pkg::RegKernelCols, cvs_pkg::CsrW'(kc));
      write_csr(cvs_pkg::RegStepSize, cvs_pkg::CsrW'(s));
   endtask

   function automatic logic signed [15:0] rand_value();
      case ($urandom_range(0, 7))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         default: return 16'($urandom);
      endcase
   endfunction

   // random beats: mostly samples, some weight reloads
   task automatic add_random(int n);
      req_beat_type b;
      for (int i = 0; i < n; i++) begin
         b.op   = ($urandom_range(0, 9) == 0) ? cvs_pkg::OpLoadWeight : cvs_pkg::OpSample;
         b.idx  = 6'($urandom);
         b.data = rand_value();
         pending_beats.push_back(b);
      end
   endtask

   initial begin
      frame_rows = 11'd64;
      frame_cols = 7'd64;
      kern_rows  = 4'd3;
      kern_cols  = 4'd3;
      stride     = 4'd1;
      cur_row    = 0;
      cur_col    = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: every kernel tap, extremes at the corners
      for (int i = 0; i < cvs_pkg::Taps; i++)
         pending_beats.push_back('{cvs_pkg::OpLoadWeight, 6'(i),
            (i == 0) ? 16'sh8000 : (i == cvs_pkg::Taps - 1) ? 16'sh7fff : 16'($urandom)});
      set_geometry(3, 4, 2, 2, 1);
      for (int i = 0; i < 12; i++)
         pending_beats.push_back('{cvs_pkg::OpSample, 6'(i * 5),
            (i % 2) ? 16'sh7fff : 16'sh8000});
      // unused register index: ignored, frame keeps going
      wait_idle();
      write_csr(RegUnused, 11'h7ff);
      add_random(40);

      set_geometry(6, 8, 3, 3, 1);     add_random(60);
      // zero values saturate
      set_geometry(0, 0, 0, 0, 0);     add_random(20);
      // oversize rows, kernel and stride saturate
      set_geometry(2047, 12, 15, 15, 15); add_random(120);
      // oversize column count saturates
      set_geometry(3, 127, 2, 2, 1);   add_random(140);
      set_geometry(10, 12, 3, 2, 2);   add_random(60);
      set_geometry(20, 64, 1, 1, 8);   add_random(40);
      // kernel taller and wider than the frame: no results
      set_geometry(4, 5, 8, 6, 1);     add_random(30);
      set_geometry(2047, 1, 8, 1, 3);  add_random(40);
      set_geometry(9, 10, 8, 8, 1);    add_random(100);
      set_geometry(12, 9, 4, 5, 3);    add_random(60);

      wait_idle();
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #40ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

### filelist.f
rtl/cvs_pkg.sv
rtl/cvs_ram.sv
rtl/cvs_front.sv
rtl/cvs_mac.sv
rtl/conv2d_valid_strided.sv
sim/tb_conv2d_valid_strided.sv
